// File: src/tmqb_pkg.sv
// ----------------------------------------------------------------------------
// tmqb_pkg
// Shared types and constants for the timestamp matched quaternion buffer.
// ----------------------------------------------------------------------------
package tmqb_pkg;

  localparam int FRAME_SLOTS_DEF = 16;
  localparam int TS_W            = 32;
  localparam int QC_W            = 16;
  localparam int SLOT_W          = 4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  // w sits in the low bits of the packed word
  typedef struct packed {
    logic signed [QC_W-1:0] z;
    logic signed [QC_W-1:0] y;
    logic signed [QC_W-1:0] x;
    logic signed [QC_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic [TS_W-1:0] ts;
    quat_t           q;
  } frame_t;

  typedef struct packed {
    logic load;
    logic step;
  } match_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

endpackage

// File: src/tmqb_if.sv
// ----------------------------------------------------------------------------
// tmqb_in_if / tmqb_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface tmqb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic        [tmqb_pkg::TS_W-1:0]     ticks;
  logic signed [tmqb_pkg::QC_W-1:0]     quat_w;
  logic signed [tmqb_pkg::QC_W-1:0]     quat_x;
  logic signed [tmqb_pkg::QC_W-1:0]     quat_y;
  logic signed [tmqb_pkg::QC_W-1:0]     quat_z;

  modport source (output valid, op, ticks, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink   (input valid, op, ticks, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface tmqb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [tmqb_pkg::SLOT_W-1:0]   slot;
  logic        [tmqb_pkg::TS_W-1:0]     time_error;
  logic signed [tmqb_pkg::QC_W-1:0]     match_w;
  logic signed [tmqb_pkg::QC_W-1:0]     match_x;
  logic signed [tmqb_pkg::QC_W-1:0]     match_y;
  logic signed [tmqb_pkg::QC_W-1:0]     match_z;

  modport source (output valid, slot, time_error, match_w, match_x, match_y,
                  match_z, input ready);
  modport sink   (input valid, slot, time_error, match_w, match_x, match_y,
                  match_z, output ready);
endinterface

// File: src/tmqb_cell.sv
// ----------------------------------------------------------------------------
// tmqb_cell
// One frame slot of the ring: direct write on insert, shift to neighbour on scan.
// ----------------------------------------------------------------------------
module tmqb_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  tmqb_pkg::frame_t shift_in,
  input  logic             wr_en,
  input  tmqb_pkg::frame_t wr_data,
  output tmqb_pkg::frame_t frame_q
);
  import tmqb_pkg::*;

  frame_t frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (wr_en) begin
      frame_r <= wr_data;
    end else if (shift_en) begin
      frame_r <= shift_in;
    end
  end

  assign frame_q = frame_r;

endmodule

// File: src/tmqb_match.sv
// ----------------------------------------------------------------------------
// tmqb_match
// Two-stage nearest-time comparator fed by the head cell of the ring.
// ----------------------------------------------------------------------------
module tmqb_match #(
  parameter int FRAME_SLOTS = tmqb_pkg::FRAME_SLOTS_DEF,
  localparam int IDX_W      = $clog2(FRAME_SLOTS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tmqb_pkg::match_ctrl_t     ctrl,
  input  tmqb_pkg::frame_t          head,
  input  logic [IDX_W-1:0]          head_idx,
  input  logic [tmqb_pkg::TS_W-1:0] query_ts,
  input  logic [IDX_W-1:0]          load_idx,
  input  tmqb_pkg::quat_t           load_quat,
  output logic [IDX_W-1:0]          best_idx,
  output logic [tmqb_pkg::TS_W-1:0] best_err,
  output tmqb_pkg::quat_t           best_quat
);
  import tmqb_pkg::*;

  logic              a_vld_r;
  logic [TS_W-1:0]   a_dist_r;
  logic [IDX_W-1:0]  a_idx_r;
  quat_t             a_quat_r;
  logic [TS_W-1:0]   tick_gap;

  logic [IDX_W-1:0]  best_idx_r;
  logic [TS_W-1:0]   best_err_r;
  quat_t             best_quat_r;

  assign tick_gap = (head.ts >= query_ts) ? (head.ts - query_ts) : (query_ts - head.ts);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    a_dist_r <= tick_gap;
    a_idx_r  <= head_idx;
    a_quat_r <= head.q;
  end

  // strict compare: on a tie the earlier slot stays
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      best_idx_r  <= load_idx;
      best_err_r  <= '0;
      best_quat_r <= load_quat;
    end else if (a_vld_r && ((a_idx_r == '0) || (a_dist_r < best_err_r))) begin
      best_idx_r  <= a_idx_r;
      best_err_r  <= a_dist_r;
      best_quat_r <= a_quat_r;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_err  = best_err_r;
  assign best_quat = best_quat_r;

endmodule

// File: src/timestamp_matched_quaternion_buffer.sv
// ----------------------------------------------------------------------------
// timestamp_matched_quaternion_buffer
// Ring of attitude frames with insert and nearest-timestamp lookup.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    op, ticks, quat_w/x/y/z
//  out_ch    out  valid / ready    slot, time_error, match_w/x/y/z
//
//  Insert: the accept moves the sequencer to EMIT, where the result beat is
//  registered. Find: the ring rotates one full turn past a single comparator,
//  one slot per cycle, then passes FLUSH before EMIT.
//  One beat in flight at a time; a held result stalls only the next emit.
//  Synchronous reset clears every slot, the write pointer and all control.
// ----------------------------------------------------------------------------
module timestamp_matched_quaternion_buffer #(
  parameter int FRAME_SLOTS = tmqb_pkg::FRAME_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tmqb_in_if.sink     in_ch,
  tmqb_out_if.source  out_ch
);
  import tmqb_pkg::*;

  localparam int IDX_W = $clog2(FRAME_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [TS_W-1:0]   ts_r;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [TS_W-1:0]   out_err_r;
  quat_t             out_quat_r;

  logic              acc;
  logic              emit_go;
  logic              shift_en;
  match_ctrl_t       mctrl;
  quat_t             in_quat;
  frame_t            wr_frame;
  frame_t            cells [FRAME_SLOTS];

  logic [IDX_W-1:0]  best_idx;
  logic [TS_W-1:0]   best_err;
  quat_t             best_quat;

  assign acc     = in_ch.valid && in_ch.ready;
  assign in_quat = '{z: in_ch.quat_z, y: in_ch.quat_y, x: in_ch.quat_x, w: in_ch.quat_w};
  assign wr_frame = '{ts: in_ch.ticks, q: in_quat};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = (in_ch.op == OP_FIND) ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready  = 1'b0;
    shift_en     = 1'b0;
    emit_go      = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_SCAN:  shift_en    = 1'b1;
      ST_FLUSH: ;
      ST_EMIT:  emit_go     = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign mctrl.load = acc && (in_ch.op == OP_INSERT);
  assign mctrl.step = shift_en;

  always_comb begin
    ptr_nxt = ptr_r;
    if (mctrl.load) begin
      ptr_nxt = (ptr_r >= LAST_IDX) ? '0 : ptr_r + 1'b1;
    end
  end

  assign scan_cnt_nxt = shift_en ? ((scan_cnt_r == LAST_IDX) ? '0 : scan_cnt_r + 1'b1)
                                 : scan_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      ts_r <= in_ch.ticks;
    end
    if (emit_go) begin
      out_slot_r <= SLOT_W'(best_idx);
      out_err_r  <= best_err;
      out_quat_r <= best_quat;
    end
  end

  // ring of slots, cell 0 is the head seen by the comparator
  for (genvar i = 0; i < FRAME_SLOTS; i++) begin : g_cell
    localparam int NEXT = (i + 1) % FRAME_SLOTS;
    tmqb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .shift_in (cells[NEXT]),
      .wr_en    (mctrl.load && (ptr_nxt == IDX_W'(i))),
      .wr_data  (wr_frame),
      .frame_q  (cells[i])
    );
  end

  tmqb_match #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctrl),
    .head      (cells[0]),
    .head_idx  (scan_cnt_r),
    .query_ts  (ts_r),
    .load_idx  (ptr_nxt),
    .load_quat (in_quat),
    .best_idx  (best_idx),
    .best_err  (best_err),
    .best_quat (best_quat)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.time_error = out_err_r;
  assign out_ch.match_w    = out_quat_r.w;
  assign out_ch.match_x    = out_quat_r.x;
  assign out_ch.match_y    = out_quat_r.y;
  assign out_ch.match_z    = out_quat_r.z;

  a_flush_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> (state_r == ST_EMIT))
    else $error("flush not followed by emit");

  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (scan_cnt_r == '0))
    else $error("scan counter not home while idle");

  a_insert_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mctrl.load |=> (best_err == '0) && (best_idx == $past(ptr_nxt)))
    else $error("insert result not loaded");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result beat raised outside emit");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the timestamp matched quaternion buffer against its own model of the
// frame ring. A short table covers cleared slots, full-range tick distances,
// ties, insert echo and pointer wrap; random inserts and lookups follow,
// mostly along a rising IMU clock, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module testbench;
  import tmqb_pkg::*;

  localparam int RING_SLOTS = FRAME_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    logic            op;
    logic [TS_W-1:0] ts;
    quat_t           q;
  } frame_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TS_W-1:0]   time_error;
    quat_t             q;
  } attitude_result_t;

  typedef struct {
    frame_req_t       req;
    bit               typed;
    attitude_result_t want;
  } bench_row_t;

  logic clk;
  logic rst_n;

  tmqb_in_if  in_bus ();
  tmqb_out_if out_bus ();

  timestamp_matched_quaternion_buffer #(
    .FRAME_SLOTS(RING_SLOTS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // model of the ring
  logic [TS_W-1:0]  ring_ts [RING_SLOTS];
  quat_t            ring_q  [RING_SLOTS];
  int unsigned      ring_head;
  logic [TS_W-1:0]  imu_clock;

  attitude_result_t pending_results [$];
  bench_row_t       directed_rows [$];
  int unsigned      mismatch_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic quat_t mk_quat(input logic [QC_W-1:0] w, x, y, z);
    quat_t q;
    q.w = w;
    q.x = x;
    q.y = y;
    q.z = z;
    return q;
  endfunction

  function automatic attitude_result_t mk_result(input logic [SLOT_W-1:0] slot,
                                                 input logic [TS_W-1:0] err,
                                                 input quat_t q);
    attitude_result_t r;
    r.slot       = slot;
    r.time_error = err;
    r.q          = q;
    return r;
  endfunction

  function automatic attitude_result_t predict_frame_access(input frame_req_t r);
    attitude_result_t res;
    logic [TS_W-1:0]  tick_gap;
    logic [TS_W-1:0]  best_dist;
    int unsigned      best;
    int unsigned      i;
    if (r.op == OP_INSERT) begin
      ring_head = (ring_head >= RING_SLOTS - 1) ? 0 : ring_head + 1;
      ring_ts[ring_head] = r.ts;
      ring_q[ring_head]  = r.q;
      res = mk_result(SLOT_W'(ring_head), '0, r.q);
    end else begin
      // strict compare: lowest slot wins a tie
      best      = 0;
      best_dist = '1;
      for (i = 0; i < RING_SLOTS; i++) begin
        tick_gap = (ring_ts[i] >= r.ts) ? ring_ts[i] - r.ts : r.ts - ring_ts[i];
        if (tick_gap < best_dist) begin
          best_dist = tick_gap;
          best      = i;
        end
      end
      res = mk_result(SLOT_W'(best), best_dist, ring_q[best]);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic op, input logic [TS_W-1:0] ts, input quat_t q,
                         input bit typed, input attitude_result_t want);
    bench_row_t row;
    row.req.op = op;
    row.req.ts = ts;
    row.req.q  = q;
    row.typed  = typed;
    row.want   = want;
    directed_rows.push_back(row);
  endtask

  function automatic int draw_wait(input int seq, input int stretch);
    return ((seq / stretch) % 4 == 3) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [QC_W-1:0] extreme_comp();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic quat_t draw_quat();
    if ($urandom_range(0, 9) == 0)
      return mk_quat(extreme_comp(), extreme_comp(), extreme_comp(), extreme_comp());
    return mk_quat(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
  endfunction

  function automatic frame_req_t draw_request();
    frame_req_t  r;
    int unsigned mode;
    r.op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_FIND;
    r.q  = draw_quat();
    mode = $urandom_range(0, 99);
    if ($urandom_range(0, 149) == 0)
      imu_clock = $urandom();
    if (mode < 60) begin
      if (r.op == OP_INSERT) begin
        imu_clock += $urandom_range(1, 2000);
        r.ts = imu_clock;
      end else begin
        r.ts = imu_clock - $urandom_range(0, 30000) + $urandom_range(0, 500);
      end
    end else if (mode < 78) begin
      // coarse grid, plenty of ties
      r.ts = $urandom_range(0, 14) * 500;
    end else if (mode < 92) begin
      r.ts = $urandom();
    end else begin
      case ($urandom_range(0, 3))
        0: r.ts = 32'h0000_0000;
        1: r.ts = 32'hFFFF_FFFF;
        2: r.ts = 32'h7FFF_FFFF;
        default: r.ts = 32'h8000_0000;
      endcase
    end
    return r;
  endfunction

  task automatic drive_request(input frame_req_t r, input int gap, input bit typed,
                               input attitude_result_t want);
    attitude_result_t predicted;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.op     <= r.op;
    in_bus.ticks  <= r.ts;
    in_bus.quat_w <= r.q.w;
    in_bus.quat_x <= r.q.x;
    in_bus.quat_y <= r.q.y;
    in_bus.quat_z <= r.q.z;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predicted = predict_frame_access(r);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic check_result();
    attitude_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected beat, slot", {28'h0, out_bus.slot}, '0);
      return;
    end
    want = pending_results.pop_front();
    if (out_bus.slot !== want.slot)
      report_mismatch("slot", {28'h0, out_bus.slot}, {28'h0, want.slot});
    if (out_bus.time_error !== want.time_error)
      report_mismatch("time_error", out_bus.time_error, want.time_error);
    if (out_bus.match_w !== want.q.w)
      report_mismatch("match_w", {16'h0, out_bus.match_w}, {16'h0, want.q.w});
    if (out_bus.match_x !== want.q.x)
      report_mismatch("match_x", {16'h0, out_bus.match_x}, {16'h0, want.q.x});
    if (out_bus.match_y !== want.q.y)
      report_mismatch("match_y", {16'h0, out_bus.match_y}, {16'h0, want.q.y});
    if (out_bus.match_z !== want.q.z)
      report_mismatch("match_z", {16'h0, out_bus.match_z}, {16'h0, want.q.z});
  endtask

  // result side
  initial begin
    int stall;
    int beats;
    out_bus.ready = 1'b0;
    beats = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait(beats, 56);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      check_result();
      beats++;
      @(negedge clk);
    end
  end

  // request side
  initial begin
    quat_t q_a, q_b, q_c, q_d;
    int    seq;
    int    i;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_INSERT;
    in_bus.ticks      = '0;
    in_bus.quat_w     = '0;
    in_bus.quat_x     = '0;
    in_bus.quat_y     = '0;
    in_bus.quat_z     = '0;
    mismatch_count    = 0;
    ring_head         = 0;
    imu_clock         = $urandom();
    seq               = 0;
    for (i = 0; i < RING_SLOTS; i++) begin
      ring_ts[i] = '0;
      ring_q[i]  = '0;
    end

    q_a = mk_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    q_b = mk_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    q_c = mk_quat(16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA);
    q_d = mk_quat(16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555);

    // cleared ring: slot 0 wins every lookup
    add_row(OP_FIND,   32'h0000_0000, q_a, 1'b1, mk_result(4'd0, 32'h0000_0000, '0));
    add_row(OP_FIND,   32'hFFFF_FFFF, q_b, 1'b1, mk_result(4'd0, 32'hFFFF_FFFF, '0));
    // first insert lands in slot 1
    add_row(OP_INSERT, 32'hFFFF_FFFF, q_a, 1'b1, mk_result(4'd1, '0, q_a));
    add_row(OP_INSERT, 32'h0000_0000, q_b, 1'b1, mk_result(4'd2, '0, q_b));
    add_row(OP_INSERT, 32'd1000,      q_c, 1'b1, mk_result(4'd3, '0, q_c));
    add_row(OP_INSERT, 32'd3000,      q_d, 1'b1, mk_result(4'd4, '0, q_d));
    // tie between slots 3 and 4
    add_row(OP_FIND,   32'd2000,      '0,  1'b0, '0);
    add_row(OP_FIND,   32'hFFFF_FFFF, '0,  1'b0, '0);
    // tie with cleared slots and slot 2
    add_row(OP_FIND,   32'h0000_0000, '0,  1'b1, mk_result(4'd0, '0, '0));
    add_row(OP_FIND,   32'h7FFF_FFFF, '0,  1'b0, '0);
    add_row(OP_FIND,   32'h8000_0000, q_c, 1'b0, '0);
    add_row(OP_FIND,   32'h0000_0001, q_d, 1'b0, '0);
    // fill slots 5..15, then wrap to 0
    for (i = 0; i < 12; i++)
      add_row(OP_INSERT, 32'h4000_0000 + i * 256,
              mk_quat(16'(i * 4099), 16'(~i), 16'(i << 12), 16'h8000 ^ 16'(i)), 1'b0, '0);
    add_row(OP_FIND,   32'h4000_0000 + 11 * 256, '0, 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      drive_request(directed_rows[k].req, draw_wait(seq, 40),
                    directed_rows[k].typed, directed_rows[k].want);
      seq++;
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) begin
        // drain before carrying on
        in_bus.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      drive_request(draw_request(), draw_wait(seq, 40), 1'b0, '0);
      seq++;
    end
    in_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (RING_SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tmqb_pkg.sv
src/tmqb_if.sv
src/tmqb_cell.sv
src/tmqb_match.sv
src/timestamp_matched_quaternion_buffer.sv
bench/testbench.sv
